/* rtl/tkcs_pkg.sv */
// Shared request codes and result flag type for the two-kind chained stack.
// No dependencies; tkcs_core and two_kind_chained_stack use it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package tkcs_pkg;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_PEEK  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    typedef struct packed {
        logic found;
        logic out_kind;
        logic overflow;
        logic replaced;
    } res_flags_t;

endpackage

`default_nettype wire

/* rtl/tkcs_entry_ram.sv */
// Entry store of the two-kind chained stack: one write port, one registered read port.
// Holds payload and prior-same-kind link per entry; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tkcs_entry_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 70
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tkcs_core.sv */
// Stack state and request logic: fill count, newest-of-kind links, and a two-deep
// cache per kind backed by tkcs_entry_ram. Depends on tkcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkcs_core #(
    parameter int STACK_DEPTH  = 32,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [1:0]              req_type,
    input  wire logic                    item_kind,
    input  wire logic [PAYLOAD_BITS-1:0] item_payload,
    output tkcs_pkg::res_flags_t         res_flags,
    output logic      [PAYLOAD_BITS-1:0] res_payload
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int EW = PAYLOAD_BITS + LW;
    localparam logic [LW-1:0] NULL_LINK = LW'(STACK_DEPTH);
    localparam logic [LW-1:0] ONE       = LW'(1);

    // Per kind: newest entry (level 1) and the one its link points at (level 2)
    logic [LW-1:0]           fill_reg, fill_next;
    logic [LW-1:0]           newest_reg   [2];
    logic [LW-1:0]           newest_next  [2];
    logic [PAYLOAD_BITS-1:0] n1_pay_reg   [2];
    logic [PAYLOAD_BITS-1:0] n1_pay_next  [2];
    logic [LW-1:0]           n1_prior_reg [2];
    logic [LW-1:0]           n1_prior_next[2];
    logic [PAYLOAD_BITS-1:0] n2_pay_reg   [2];
    logic [PAYLOAD_BITS-1:0] n2_pay_next  [2];
    logic [LW-1:0]           n2_prior_reg [2];
    logic [LW-1:0]           n2_prior_next[2];
    logic                    rd_pend_reg, rd_pend_next;
    logic                    rd_kind_reg, rd_kind_next;

    logic [PAYLOAD_BITS-1:0] n2e_pay  [2];
    logic [LW-1:0]           n2e_prior[2];

    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [EW-1:0]           wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [EW-1:0]           rd_data;

    logic                    has_top;
    logic [LW-1:0]           top_idx;
    logic                    top_kind;
    logic                    k;

    tkcs_entry_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign has_top  = (fill_reg != '0);
    assign top_idx  = fill_reg - ONE;
    // The top entry is always the newest of its own kind
    assign top_kind = (newest_reg[1] == top_idx);
    assign k        = item_kind;

    // The refill read lands in the cycle after its pop; take it over the cached copy
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (rd_pend_reg && (rd_kind_reg == 1'(i)))
            begin
                n2e_pay[i]   = rd_data[PAYLOAD_BITS-1:0];
                n2e_prior[i] = rd_data[EW-1:PAYLOAD_BITS];
            end
            else
            begin
                n2e_pay[i]   = n2_pay_reg[i];
                n2e_prior[i] = n2_prior_reg[i];
            end
        end
    end

    always_comb
    begin
        fill_next    = fill_reg;
        rd_pend_next = 1'b0;
        rd_kind_next = rd_kind_reg;
        for (int i = 0; i < 2; i++)
        begin
            newest_next[i]   = newest_reg[i];
            n1_pay_next[i]   = n1_pay_reg[i];
            n1_prior_next[i] = n1_prior_reg[i];
            n2_pay_next[i]   = n2e_pay[i];
            n2_prior_next[i] = n2e_prior[i];
        end
        wr_en       = 1'b0;
        wr_addr     = top_idx[AW-1:0];
        wr_data     = {NULL_LINK, item_payload};
        rd_en       = 1'b0;
        rd_addr     = n2e_prior[top_kind][AW-1:0];
        res_flags   = '0;
        res_payload = '0;

        unique case (req_type)
            tkcs_pkg::REQ_PUSH:
            begin
                if (has_top && (top_kind == k))
                begin
                    res_flags.replaced = 1'b1;
                    wr_en          = step;
                    wr_addr        = top_idx[AW-1:0];
                    wr_data        = {n1_prior_reg[k], item_payload};
                    n1_pay_next[k] = item_payload;
                end
                else if (fill_reg == NULL_LINK)
                begin
                    res_flags.overflow = 1'b1;
                end
                else
                begin
                    wr_en            = step;
                    wr_addr          = fill_reg[AW-1:0];
                    wr_data          = {newest_reg[k], item_payload};
                    n2_pay_next[k]   = n1_pay_reg[k];
                    n2_prior_next[k] = n1_prior_reg[k];
                    n1_pay_next[k]   = item_payload;
                    n1_prior_next[k] = newest_reg[k];
                    newest_next[k]   = fill_reg;
                    fill_next        = fill_reg + ONE;
                end
            end
            tkcs_pkg::REQ_POP:
            begin
                if (has_top)
                begin
                    res_flags.found         = 1'b1;
                    res_flags.out_kind      = top_kind;
                    res_payload             = n1_pay_reg[top_kind];
                    // Promote level 2 and fetch the entry behind it
                    newest_next[top_kind]   = n1_prior_reg[top_kind];
                    n1_pay_next[top_kind]   = n2e_pay[top_kind];
                    n1_prior_next[top_kind] = n2e_prior[top_kind];
                    fill_next               = top_idx;
                    if (n2e_prior[top_kind] != NULL_LINK)
                    begin
                        rd_en        = step;
                        rd_pend_next = 1'b1;
                        rd_kind_next = top_kind;
                    end
                end
            end
            tkcs_pkg::REQ_PEEK:
            begin
                if (newest_reg[k] != NULL_LINK)
                begin
                    res_flags.found    = 1'b1;
                    res_flags.out_kind = k;
                    res_payload        = n1_pay_reg[k];
                end
            end
            tkcs_pkg::REQ_CLEAR:
            begin
                fill_next      = '0;
                newest_next[0] = NULL_LINK;
                newest_next[1] = NULL_LINK;
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            newest_reg[0] <= NULL_LINK;
            newest_reg[1] <= NULL_LINK;
            rd_pend_reg   <= 1'b0;
            rd_kind_reg   <= 1'b0;
        end
        else if (step)
        begin
            fill_reg      <= fill_next;
            newest_reg[0] <= newest_next[0];
            newest_reg[1] <= newest_next[1];
            rd_pend_reg   <= rd_pend_next;
            rd_kind_reg   <= rd_kind_next;
        end
        else
        begin
            // Hold the landed refill in the cache before the read data moves on
            rd_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (step)
            begin
                n1_pay_reg[i]   <= n1_pay_next[i];
                n1_prior_reg[i] <= n1_prior_next[i];
                n2_pay_reg[i]   <= n2_pay_next[i];
                n2_prior_reg[i] <= n2_prior_next[i];
            end
            else
            begin
                n2_pay_reg[i]   <= n2e_pay[i];
                n2_prior_reg[i] <= n2e_prior[i];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/two_kind_chained_stack.sv */
// Top level of the two-kind chained stack: input register, result register, handshakes.
// Depends on tkcs_pkg and tkcs_core (which instantiates tkcs_entry_ram).
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------------
//  input   | in_valid / in_ready | req_type, item_kind, item_payload
//  result  | out_valid/out_ready | found, out_kind, out_payload, overflow, replaced
//
// One beat per cycle sustained while out_ready stays high; a request passes the input
// register, then the result register, before out_valid rises. Each request touches the
// per-kind cache registers and at most one entry store write and one refill read.
// Reset empties the stack at once; no clearing pass.
// A stalled result holds both registers; the input register still frees when the
// result register drains.
`timescale 1ns / 1ps
`default_nettype none

module two_kind_chained_stack #(
    parameter int STACK_DEPTH  = 32,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              req_type,
    input  wire logic                    item_kind,
    input  wire logic [PAYLOAD_BITS-1:0] item_payload,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         found,
    output logic                         out_kind,
    output logic      [PAYLOAD_BITS-1:0] out_payload,
    output logic                         overflow,
    output logic                         replaced
);

    logic                    s1_valid_reg;
    logic [1:0]              s1_req_reg;
    logic                    s1_kind_reg;
    logic [PAYLOAD_BITS-1:0] s1_pay_reg;

    logic                    res_valid_reg;
    tkcs_pkg::res_flags_t    res_flags_reg;
    logic [PAYLOAD_BITS-1:0] res_pay_reg;

    tkcs_pkg::res_flags_t    core_flags;
    logic [PAYLOAD_BITS-1:0] core_payload;
    logic                    advance;
    logic                    in_beat;

    assign advance  = s1_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_beat  = in_valid && in_ready;

    tkcs_core #(
        .STACK_DEPTH  (STACK_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .req_type     (s1_req_reg),
        .item_kind    (s1_kind_reg),
        .item_payload (s1_pay_reg),
        .res_flags    (core_flags),
        .res_payload  (core_payload)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            s1_req_reg  <= req_type;
            s1_kind_reg <= item_kind;
            s1_pay_reg  <= item_payload;
        end
        if (advance)
        begin
            res_flags_reg <= core_flags;
            res_pay_reg   <= core_payload;
        end
    end

    assign out_valid   = res_valid_reg;
    assign found       = res_flags_reg.found;
    assign out_kind    = res_flags_reg.out_kind;
    assign out_payload = res_pay_reg;
    assign overflow    = res_flags_reg.overflow;
    assign replaced    = res_flags_reg.replaced;

endmodule

`default_nettype wire

/* bench/two_kind_chained_stack_tb.sv */
// Self-checking bench for two_kind_chained_stack: a scripted walk through the corner cases
// and then biased random traffic; each result is checked by script row or stack predictor.
// Depends on tkcs_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module two_kind_chained_stack_tb;

    localparam int STACK_DEPTH  = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int NULL_LINK    = STACK_DEPTH;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 150;

    typedef struct packed {
        logic [1:0]              op;
        logic                    kind;
        logic [PAYLOAD_BITS-1:0] payload;
    } stack_req_t;

    typedef struct packed {
        logic                    found;
        logic                    kind;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    overflow;
        logic                    replaced;
    } stack_res_t;

    typedef struct packed {
        stack_req_t rq;
        logic [5:0] reps;
        logic       alt;
        logic       typed;
        stack_res_t want;
    } script_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [1:0]              req_type;
    logic                    item_kind;
    logic [PAYLOAD_BITS-1:0] item_payload;
    logic                    out_valid;
    logic                    out_ready;
    logic                    found;
    logic                    out_kind;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    overflow;
    logic                    replaced;

    // Predictor state
    logic [PAYLOAD_BITS-1:0] shadow_payload [STACK_DEPTH];
    logic                    shadow_kind    [STACK_DEPTH];
    int unsigned             shadow_prior   [STACK_DEPTH];
    int unsigned             shadow_newest  [2];
    int unsigned             shadow_fill;

    stack_res_t  awaited_responses[$];
    script_row_t script[$];

    int mismatches;
    int results_seen;
    int req_count [4];
    int overflow_count;
    int replace_count;
    int deepest;

    two_kind_chained_stack #(
        .STACK_DEPTH  (STACK_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .item_kind    (item_kind),
        .item_payload (item_payload),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .out_kind     (out_kind),
        .out_payload  (out_payload),
        .overflow     (overflow),
        .replaced     (replaced)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the predictor state and return the response it produces.
    function automatic stack_res_t stack_response(input stack_req_t rq);
        stack_res_t  r;
        int unsigned top;
        r = '0;
        req_count[rq.op]++;
        case (rq.op)
            tkcs_pkg::REQ_PUSH:
            begin
                if (shadow_fill > 0 && shadow_kind[shadow_fill-1] == rq.kind)
                begin
                    shadow_payload[shadow_fill-1] = rq.payload;
                    r.replaced = 1'b1;
                    replace_count++;
                end
                else if (shadow_fill >= STACK_DEPTH)
                begin
                    r.overflow = 1'b1;
                    overflow_count++;
                end
                else
                begin
                    shadow_payload[shadow_fill] = rq.payload;
                    shadow_kind[shadow_fill]    = rq.kind;
                    shadow_prior[shadow_fill]   = shadow_newest[rq.kind];
                    shadow_newest[rq.kind]      = shadow_fill;
                    shadow_fill++;
                    if (shadow_fill > deepest)
                        deepest = shadow_fill;
                end
            end
            tkcs_pkg::REQ_POP:
            begin
                if (shadow_fill > 0)
                begin
                    top       = shadow_fill - 1;
                    r.found   = 1'b1;
                    r.kind    = shadow_kind[top];
                    r.payload = shadow_payload[top];
                    // restore the link of the popped entry's kind
                    shadow_newest[shadow_kind[top]] = shadow_prior[top];
                    shadow_fill = top;
                end
            end
            tkcs_pkg::REQ_PEEK:
            begin
                if (shadow_newest[rq.kind] < STACK_DEPTH)
                begin
                    r.found   = 1'b1;
                    r.kind    = shadow_kind[shadow_newest[rq.kind]];
                    r.payload = shadow_payload[shadow_newest[rq.kind]];
                end
            end
            default:
            begin
                shadow_fill      = 0;
                shadow_newest[0] = NULL_LINK;
                shadow_newest[1] = NULL_LINK;
            end
        endcase
        return r;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(15, 40);
    endfunction

    function automatic script_row_t script_row(
        input logic [1:0]              op,
        input logic                    kind,
        input logic [PAYLOAD_BITS-1:0] pay,
        input int                      reps,
        input logic                    alt,
        input logic                    typed,
        input logic                    w_found,
        input logic                    w_kind,
        input logic [PAYLOAD_BITS-1:0] w_pay,
        input logic                    w_ovf,
        input logic                    w_repl
    );
        script_row_t row;
        row.rq    = '{op: op, kind: kind, payload: pay};
        row.reps  = reps[5:0];
        row.alt   = alt;
        row.typed = typed;
        row.want  = '{found: w_found, kind: w_kind, payload: w_pay,
                      overflow: w_ovf, replaced: w_repl};
        return row;
    endfunction

    // Offer one beat after an optional gap, hold it until accepted, then log its response.
    task automatic offer_request(input stack_req_t rq, input int gap, input logic typed,
                                 input stack_res_t want);
        stack_res_t calc;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq.op;
        item_kind    <= rq.kind;
        item_payload <= rq.payload;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        calc = stack_response(rq);
        awaited_responses.push_back(typed ? want : calc);
    endtask

    // Result side: random stalls, calm stretches, and one long hold to back the block up.
    initial
    begin : result_sink
        int  hold_left;
        int  calm_left;
        logic held_long;
        hold_left = 0;
        calm_left = 0;
        held_long = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!held_long && results_seen >= 80)
            begin
                held_long = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 149) == 0)
                calm_left = $urandom_range(30, 120);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm_left == 0 && $urandom_range(0, 3) == 0)
            begin
                hold_left = pick_gap() - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        stack_res_t got;
        stack_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {found, out_kind, out_payload, overflow, replaced};
            results_seen++;
            if (awaited_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result beat: ", $time,
                             "found %b kind %b payload %h ovf %b repl %b",
                             got.found, got.kind, got.payload, got.overflow, got.replaced);
            end
            else
            begin
                want = awaited_responses.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result %0d mismatch (exp/got): ", $time, results_seen,
                                 "found %b/%b kind %b/%b payload %h/%h ",
                                 want.found, got.found, want.kind, got.kind,
                                 want.payload, got.payload,
                                 "ovf %b/%b repl %b/%b",
                                 want.overflow, got.overflow, want.replaced, got.replaced);
                end
            end
        end
    end

    // Abort when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        stack_req_t  rq;
        script_row_t row;
        int          n;
        int          i;
        int          gap;
        int          block_left;
        int          mode;
        int          roll;
        logic        calm;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = tkcs_pkg::REQ_PUSH;
        item_kind    = 1'b0;
        item_payload = '0;
        mismatches   = 0;
        results_seen = 0;
        overflow_count = 0;
        replace_count  = 0;
        deepest        = 0;
        req_count      = '{default: 0};
        shadow_fill    = 0;
        shadow_newest[0] = NULL_LINK;
        shadow_newest[1] = NULL_LINK;
        block_left = 0;
        mode       = 0;
        calm       = 1'b0;

        // op, kind, payload, reps, alt, typed | found, kind, payload, ovf, repl
        script.push_back(script_row(tkcs_pkg::REQ_POP,   0, '0, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  0, '0, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  1, '1, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  0, '1, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  0, '0, 1, 0, 1, 0, 0, '0, 0, 1));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  0, '1, 1, 0, 1, 1, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  1, 64'h8000_0000_0000_0001, 1, 0, 1,
                                    0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  0, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  1, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  1, 64'h5555_5555_5555_5555, 1, 0, 1,
                                    0, 0, '0, 0, 1));
        script.push_back(script_row(tkcs_pkg::REQ_POP,   0, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_POP,   1, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_POP,   0, '0, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  1, 64'hAAAA_AAAA_AAAA_AAAA, 1, 0, 0,
                                    0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_CLEAR, 0, '0, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  1, '0, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_POP,   1, '0, 1, 0, 1, 0, 0, '0, 0, 0));
        // fill to the brim with alternating kinds, then push past it
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  0, 64'h0123_4567_89AB_CDEF,
                                    STACK_DEPTH, 1, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  0, '1, 1, 0, 1, 0, 0, '0, 1, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  1, '1, 1, 0, 1, 0, 0, '0, 0, 1));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  0, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_POP,   0, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PUSH,  1, '0, 1, 0, 0, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_CLEAR, 1, '1, 1, 0, 1, 0, 0, '0, 0, 0));
        script.push_back(script_row(tkcs_pkg::REQ_PEEK,  0, '0, 1, 0, 1, 0, 0, '0, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            row = script[r];
            for (i = 0; i < row.reps; i++)
            begin
                rq = row.rq;
                if (row.alt)
                begin
                    rq.kind    = row.rq.kind ^ i[0];
                    rq.payload = row.rq.payload ^ PAYLOAD_BITS'(i);
                end
                gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
                offer_request(rq, gap, row.typed, row.want);
            end
        end

        // Random traffic in blocks: grow toward full, drain, or mix.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (block_left == 0)
            begin
                block_left = $urandom_range(20, 60);
                mode       = $urandom_range(0, 2);
                calm       = ($urandom_range(0, 3) == 0);
            end
            block_left--;
            roll = $urandom_range(0, 99);
            case (mode)
                0:       rq.op = (roll < 85) ? tkcs_pkg::REQ_PUSH :
                                 (roll < 92) ? tkcs_pkg::REQ_POP  :
                                 (roll < 99) ? tkcs_pkg::REQ_PEEK : tkcs_pkg::REQ_CLEAR;
                1:       rq.op = (roll < 20) ? tkcs_pkg::REQ_PUSH :
                                 (roll < 70) ? tkcs_pkg::REQ_POP  :
                                 (roll < 96) ? tkcs_pkg::REQ_PEEK : tkcs_pkg::REQ_CLEAR;
                default: rq.op = (roll < 40) ? tkcs_pkg::REQ_PUSH :
                                 (roll < 65) ? tkcs_pkg::REQ_POP  :
                                 (roll < 93) ? tkcs_pkg::REQ_PEEK : tkcs_pkg::REQ_CLEAR;
            endcase
            // favor the other kind on push so the stack actually grows
            if (rq.op == tkcs_pkg::REQ_PUSH && shadow_fill > 0 && $urandom_range(0, 99) < 80)
                rq.kind = ~shadow_kind[shadow_fill-1];
            else
                rq.kind = 1'($urandom_range(0, 1));
            roll = $urandom_range(0, 9);
            if (roll == 0)
                rq.payload = '0;
            else if (roll == 1)
                rq.payload = '1;
            else
                rq.payload = {$urandom, $urandom};
            gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
            offer_request(rq, gap, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (awaited_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d push, %0d pop, %0d peek and %0d clear requests.",
                 results_seen, req_count[tkcs_pkg::REQ_PUSH], req_count[tkcs_pkg::REQ_POP],
                 req_count[tkcs_pkg::REQ_PEEK], req_count[tkcs_pkg::REQ_CLEAR]);
        $display("Deepest fill %0d of %0d; %0d overflows, %0d top overwrites, %0d mismatches.",
                 deepest, STACK_DEPTH, overflow_count, replace_count, mismatches);
        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/tkcs_pkg.sv
rtl/tkcs_entry_ram.sv
rtl/tkcs_core.sv
rtl/two_kind_chained_stack.sv
bench/two_kind_chained_stack_tb.sv
